// File: src/mandelbrot_escape_time_core_defines.svh
// Assertion helpers used by the checker in met_checker.sv.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH

// Checked only outside reset.
`define MET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/met_pkg.sv
`timescale 1ns / 1ps
package met_pkg;

  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int CNT_W      = 16;
  localparam int PIX_W      = 10;
  localparam int FRAC_BITS  = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // iteration ring depth, one slot per stage
  localparam int RING_STAGES = 4;
  localparam int TAG_W       = $clog2(RING_STAGES);

  localparam int PROD_W   = 2 * COORD_W;
  localparam int SQ_W     = PROD_W - FRAC_BITS;
  localparam int CROSS_W  = PROD_W - FRAC_BITS + 1;
  localparam int SAT_IN_W = 44;
  localparam int OFFS_W   = PIX_W + STEP_W;

  // |z|^2 escape bound, 4.0 in the truncated square scale
  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  localparam logic [COORD_W-1:0] X_LEFT_RESET   = 32'hE000_0000;
  localparam logic [COORD_W-1:0] Y_TOP_RESET    = 32'h1000_0000;
  localparam logic [STEP_W-1:0]  X_STEP_RESET   = 31'h000C_0000;
  localparam logic [STEP_W-1:0]  Y_STEP_RESET   = 31'h0008_0000;
  localparam logic [CNT_W-1:0]   MAX_ITER_RESET = 16'd255;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
    coord_t           cx;
    coord_t           cy;
  } point_t;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic [TAG_W-1:0] tag;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
    coord_t           cx;
    coord_t           cy;
    coord_t           zx;
    coord_t           zy;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
    logic [CNT_W-1:0] count;
  } retire_t;

  // clamp a wide two's complement value into a coordinate word
  function automatic coord_t sat32(input logic [SAT_IN_W-1:0] v);
    coord_t r;
    if (v[SAT_IN_W-1:COORD_W-1] == {(SAT_IN_W - COORD_W + 1){v[SAT_IN_W-1]}}) begin
      r = v[COORD_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W - 1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: src/met_coord.sv
`timescale 1ns / 1ps
module met_coord (
  input  logic                         clk,
  input  logic                         rst,
  input  met_pkg::coord_t              x_left,
  input  met_pkg::coord_t              y_top,
  input  logic [met_pkg::STEP_W-1:0]   x_step,
  input  logic [met_pkg::STEP_W-1:0]   y_step,
  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  logic [met_pkg::PIX_W-1:0]    pixel_row,
  input  logic [met_pkg::PIX_W-1:0]    pixel_col,
  output logic                         pt_valid,
  input  logic                         pt_ready,
  output met_pkg::point_t              pt
);
  import met_pkg::*;

  logic              v1;
  logic [PIX_W-1:0]  row1;
  logic [PIX_W-1:0]  col1;
  logic [OFFS_W-1:0] offs_x;
  logic [OFFS_W-1:0] offs_y;
  logic              v2;
  point_t            pt2;
  logic              ready1;
  logic              ready2;
  logic [SAT_IN_W-1:0] sum_x;
  logic [SAT_IN_W-1:0] sum_y;

  assign ready2      = !v2 || pt_ready;
  assign ready1      = !v1 || ready2;
  assign pixel_ready = ready1;
  assign pt_valid    = v2;
  assign pt          = pt2;

  // stage 1: scaled offsets from the origin
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && pixel_valid) begin
      row1   <= pixel_row;
      col1   <= pixel_col;
      offs_x <= OFFS_W'(pixel_col) * OFFS_W'(x_step);
      offs_y <= OFFS_W'(pixel_row) * OFFS_W'(y_step);
    end
  end

  // stage 2: add to the origin and clamp
  always_comb begin
    sum_x = {{(SAT_IN_W - COORD_W){x_left[COORD_W-1]}}, x_left}
          + {{(SAT_IN_W - OFFS_W){1'b0}}, offs_x};
    sum_y = {{(SAT_IN_W - COORD_W){y_top[COORD_W-1]}}, y_top}
          - {{(SAT_IN_W - OFFS_W){1'b0}}, offs_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      pt2.row <= row1;
      pt2.col <= col1;
      pt2.cx  <= sat32(sum_x);
      pt2.cy  <= sat32(sum_y);
    end
  end

endmodule

// File: src/met_ring.sv
`timescale 1ns / 1ps
module met_ring (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [met_pkg::CNT_W-1:0]  max_iterations,
  input  logic                       pt_valid,
  output logic                       pt_ready,
  input  met_pkg::point_t            pt,
  output logic                       ret_valid,
  input  logic                       ret_ready,
  output met_pkg::retire_t           ret
);
  import met_pkg::*;

  // four slots rotate every cycle; each pass is one z update
  slot_t s0;
  slot_t s1;
  slot_t s2;
  slot_t s3;
  slot_t s0_next;
  slot_t s3_next;

  logic [PROD_W-1:0]  p_xx;
  logic [PROD_W-1:0]  p_yy;
  logic [PROD_W-1:0]  p_xy;
  logic [PROD_W-1:0]  zx_ext;
  logic [PROD_W-1:0]  zy_ext;

  logic [SQ_W-1:0]     sx;
  logic [SQ_W-1:0]     sy;
  logic [CROSS_W-1:0]  xy2;
  logic [SQ_W:0]       mag;
  logic                escape_next;
  logic [SAT_IN_W-1:0] zx_sum_next;
  logic [SAT_IN_W-1:0] zy_sum_next;
  logic                escape;
  logic [SAT_IN_W-1:0] zx_sum;
  logic [SAT_IN_W-1:0] zy_sum;

  logic [TAG_W-1:0] enter_tag;
  logic [TAG_W-1:0] retire_tag;
  logic             retire_fire;
  logic             load;

  // s0 -> s1: exact squares and cross product
  always_comb begin
    zx_ext = {{COORD_W{s0.zx[COORD_W-1]}}, s0.zx};
    zy_ext = {{COORD_W{s0.zy[COORD_W-1]}}, s0.zy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= s0;
    end
  end

  always_ff @(posedge clk) begin
    p_xx <= zx_ext * zx_ext;
    p_yy <= zy_ext * zy_ext;
    p_xy <= zx_ext * zy_ext;
  end

  // s1 -> s2: truncate, escape compare, unclamped next z
  always_comb begin
    sx          = p_xx[PROD_W-1:FRAC_BITS];
    sy          = p_yy[PROD_W-1:FRAC_BITS];
    xy2         = p_xy[PROD_W-1:FRAC_BITS-1];   // floor(2*zx*zy)
    mag         = {1'b0, sx} + {1'b0, sy};
    escape_next = (mag >= ESC_LIMIT);
    zx_sum_next = {{(SAT_IN_W - SQ_W){1'b0}}, sx}
                - {{(SAT_IN_W - SQ_W){1'b0}}, sy}
                + {{(SAT_IN_W - COORD_W){s1.cx[COORD_W-1]}}, s1.cx};
    zy_sum_next = {{(SAT_IN_W - CROSS_W){xy2[CROSS_W-1]}}, xy2}
                + {{(SAT_IN_W - COORD_W){s1.cy[COORD_W-1]}}, s1.cy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    escape <= escape_next;
    zx_sum <= zx_sum_next;
    zy_sum <= zy_sum_next;
  end

  // s2 -> s3: limit check comes before the escape test
  always_comb begin
    s3_next = s2;
    if (s2.valid && !s2.done) begin
      if (s2.count == max_iterations) begin
        s3_next.done = 1'b1;
      end else if (escape) begin
        s3_next.done = 1'b1;
      end else begin
        s3_next.zx    = sat32(zx_sum);
        s3_next.zy    = sat32(zy_sum);
        s3_next.count = s2.count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3 <= s3_next;
    end
  end

  // s3 -> s0: in-order retire by tag, then refill the free slot
  assign ret_valid   = s3.valid && s3.done && (s3.tag == retire_tag);
  assign retire_fire = ret_valid && ret_ready;
  assign pt_ready    = !s3.valid || retire_fire;
  assign load        = pt_valid && pt_ready;

  always_comb begin
    ret.row   = s3.row;
    ret.col   = s3.col;
    ret.count = s3.count;
  end

  always_comb begin
    s0_next = s3;
    if (retire_fire) begin
      s0_next.valid = 1'b0;
    end
    if (load) begin
      s0_next.valid = 1'b1;
      s0_next.done  = 1'b0;
      s0_next.tag   = enter_tag;
      s0_next.row   = pt.row;
      s0_next.col   = pt.col;
      s0_next.cx    = pt.cx;
      s0_next.cy    = pt.cy;
      s0_next.zx    = '0;
      s0_next.zy    = '0;
      s0_next.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0 <= s0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_tag  <= '0;
      retire_tag <= '0;
    end else begin
      if (load) begin
        enter_tag <= enter_tag + TAG_W'(1);
      end
      if (retire_fire) begin
        retire_tag <= retire_tag + TAG_W'(1);
      end
    end
  end

endmodule

// File: src/mandelbrot_escape_time_core.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time engine, Q4.28 fixed point. A pixel passes a two-stage
// coordinate pipeline and then joins a four-slot iteration ring in which every
// slot does one z = z*z + c update per pass around the ring (multiply,
// add/compare, clamp, retire/refill). A pixel's iteration count n runs up to
// max_iterations, and up to four pixels share the ring. Results leave in input
// order, so a long pixel holds back finished ones behind it. An entering pixel
// waits for a free slot; the result register decouples a stalled consumer from
// the ring, which keeps rotating.
module mandelbrot_escape_time_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [met_pkg::PIX_W-1:0]       pixel_row,
  input  logic [met_pkg::PIX_W-1:0]       pixel_col,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [met_pkg::PIX_W-1:0]       result_row,
  output logic [met_pkg::PIX_W-1:0]       result_col,
  output logic [met_pkg::CNT_W-1:0]       iteration_count,
  output logic                            in_set
);
  import met_pkg::*;

  coord_t             x_left;
  coord_t             y_top;
  logic [STEP_W-1:0]  x_step;
  logic [STEP_W-1:0]  y_step;
  logic [CNT_W-1:0]   max_iterations;

  logic    pt_valid;
  logic    pt_ready;
  point_t  pt;
  logic    ret_valid;
  logic    ret_ready;
  retire_t ret;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_left         <= X_LEFT_RESET;
      y_top          <= Y_TOP_RESET;
      x_step         <= X_STEP_RESET;
      y_step         <= Y_STEP_RESET;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_X_LEFT:   x_left         <= cfg_data[COORD_W-1:0];
        CFG_Y_TOP:    y_top          <= cfg_data[COORD_W-1:0];
        CFG_X_STEP:   x_step         <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:   y_step         <= cfg_data[STEP_W-1:0];
        CFG_MAX_ITER: max_iterations <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  met_coord u_coord (
    .clk         (clk),
    .rst         (rst),
    .x_left      (x_left),
    .y_top       (y_top),
    .x_step      (x_step),
    .y_step      (y_step),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt          (pt)
  );

  met_ring u_ring (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .pt_valid       (pt_valid),
    .pt_ready       (pt_ready),
    .pt             (pt),
    .ret_valid      (ret_valid),
    .ret_ready      (ret_ready),
    .ret            (ret)
  );

  // result register
  assign ret_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ret_ready) begin
      result_valid <= ret_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ret_valid && ret_ready) begin
      result_row      <= ret.row;
      result_col      <= ret.col;
      iteration_count <= ret.count;
      in_set          <= (ret.count == max_iterations);
    end
  end

endmodule

// File: src/met_checker.sv
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_core_defines.svh"
module met_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [met_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            pixel_valid,
  input logic                            pixel_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [met_pkg::CNT_W-1:0]       iteration_count,
  input logic                            in_set
);
  import met_pkg::*;

  logic [CNT_W-1:0] shadow_max;
  logic [3:0]       outstanding;
  logic             in_fire;
  logic             out_fire;

  assign in_fire  = pixel_valid && pixel_ready;
  assign out_fire = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_max <= MAX_ITER_RESET;
    end else if (cfg_write && (cfg_index == CFG_MAX_ITER)) begin
      shadow_max <= cfg_data[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(in_fire) - 4'(out_fire);
    end
  end

  `MET_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid, "result dropped")
  `MET_ASSERT(a_in_set_flag, result_valid |-> (in_set == (iteration_count == shadow_max)), "in_set mismatch")
  `MET_ASSERT(a_count_limit, result_valid |-> (iteration_count <= shadow_max), "count above limit")
  `MET_ASSERT(a_no_phantom, result_valid |-> (outstanding != 4'd0), "result without pixel")
  `MET_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !result_valid, "valid after reset")

endmodule

bind mandelbrot_escape_time_core met_checker u_met_checker (.*);

// File: sim/mandelbrot_escape_time_core_tb.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_core_tb;

  localparam int FRAC           = met_pkg::FRAC_BITS;
  localparam int PW             = met_pkg::PIX_W;
  localparam int CW             = met_pkg::CNT_W;
  localparam int IDLE_PCT       = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 1_000_000;
  localparam int VIEWS          = 4;
  localparam int PIXELS_PER_VIEW = 100;
  localparam int STEADY_PIXELS  = 80;

  typedef struct {
    logic [PW-1:0] row;
    logic [PW-1:0] col;
    logic [CW-1:0] count;
    logic          in_set;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_write = 1'b0;
  logic [met_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [met_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                             pixel_valid = 1'b0;
  logic                             pixel_ready;
  logic [PW-1:0]                    pixel_row = '0;
  logic [PW-1:0]                    pixel_col = '0;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic [PW-1:0]                    result_row;
  logic [PW-1:0]                    result_col;
  logic [CW-1:0]                    iteration_count;
  logic                             in_set;

  // predictor copy of the view registers, reset values as in met_pkg
  logic signed [31:0] view_x_left = -32'sd536870912;
  logic signed [31:0] view_y_top  = 32'sd268435456;
  logic [30:0]        view_x_step = 31'd786432;
  logic [30:0]        view_y_step = 31'd524288;
  logic [CW-1:0]      iter_limit  = 16'd255;

  pixel_result_t pending_pixels[$];
  int  error_count  = 0;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;
  bit  hold_request = 1'b0;

  always #1 clk = ~clk;

  mandelbrot_escape_time_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pixel_valid     (pixel_valid),
    .pixel_ready     (pixel_ready),
    .pixel_row       (pixel_row),
    .pixel_col       (pixel_col),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_row      (result_row),
    .result_col      (result_col),
    .iteration_count (iteration_count),
    .in_set          (in_set)
  );

  function automatic longint clamp_word(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // escape-time iteration in Q4.28, squares truncated toward minus infinity
  function automatic pixel_result_t escape_time_of(input logic [PW-1:0] row,
                                                   input logic [PW-1:0] col);
    longint cx, cy, zx, zy, sx, sy, xy_term;
    int unsigned count;
    pixel_result_t r;
    cx = clamp_word(longint'(view_x_left) + longint'(col) * longint'(view_x_step));
    cy = clamp_word(longint'(view_y_top) - longint'(row) * longint'(view_y_step));
    zx = 0;
    zy = 0;
    count = 0;
    while (count < iter_limit) begin
      sx = (zx * zx) >>> FRAC;
      sy = (zy * zy) >>> FRAC;
      if (sx + sy >= (longint'(4) <<< FRAC)) break;
      xy_term = (zx * zy) >>> (FRAC - 1);
      zx = clamp_word(sx - sy + cx);
      zy = clamp_word(xy_term + cy);
      count++;
    end
    r.row    = row;
    r.col    = col;
    r.count  = count[CW-1:0];
    r.in_set = (count == iter_limit);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d count %0d",
                                  result_row, result_col, iteration_count));
      end else begin
        want = pending_pixels.pop_front();
        if (result_row !== want.row)
          report_mismatch($sformatf("result_row %0d, want %0d", result_row, want.row));
        if (result_col !== want.col)
          report_mismatch($sformatf("result_col %0d, want %0d", result_col, want.col));
        if (iteration_count !== want.count)
          report_mismatch($sformatf("iteration_count %0d, want %0d (row %0d col %0d)",
                                    iteration_count, want.count, want.row, want.col));
        if (in_set !== want.in_set)
          report_mismatch($sformatf("in_set %0b, want %0b (row %0d col %0d)",
                                    in_set, want.in_set, want.row, want.col));
      end
    end
  end

  // no transaction on either channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic write_register(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] data);
    case (idx)
      met_pkg::CFG_X_LEFT:   view_x_left = data;
      met_pkg::CFG_Y_TOP:    view_y_top  = data;
      met_pkg::CFG_X_STEP:   view_x_step = data[30:0];
      met_pkg::CFG_Y_STEP:   view_y_step = data[30:0];
      met_pkg::CFG_MAX_ITER: iter_limit  = data[CW-1:0];
      default: ;
    endcase
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_view(input logic [31:0] x_left, input logic [31:0] y_top,
                            input logic [31:0] x_step, input logic [31:0] y_step,
                            input logic [31:0] limit);
    write_register(met_pkg::CFG_X_LEFT, x_left);
    write_register(met_pkg::CFG_Y_TOP, y_top);
    write_register(met_pkg::CFG_X_STEP, x_step);
    write_register(met_pkg::CFG_Y_STEP, y_step);
    write_register(met_pkg::CFG_MAX_ITER, limit);
  endtask

  // valid stays up between back-to-back pixels; it drops only for a gap or a drain
  task automatic send_pixel(input logic [PW-1:0] row, input logic [PW-1:0] col);
    pixel_result_t want;
    want = escape_time_of(row, col);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_row   <= row;
    pixel_col   <= col;
    do @(posedge clk); while (!pixel_ready);
    pending_pixels.insert(pending_pixels.size(), want);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(PW'($urandom), PW'($urandom));
  endtask

  task automatic wait_for_drain;
    pixel_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_view;
    logic [PW-1:0] rows[9] = '{0, 0, 1023, 1023, 10'h2AA, 10'h155, 512, 512, 256};
    logic [PW-1:0] cols[9] = '{0, 1023, 0, 1023, 10'h155, 10'h2AA, 683, 512, 300};
    for (int i = 0; i < 9; i++) send_pixel(rows[i], cols[i]);
    wait_for_drain();
  endtask

  task automatic test_iteration_limits;
    // a zero limit reports every pixel inside the set with count zero
    write_register(met_pkg::CFG_MAX_ITER, 32'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_for_drain();
    write_register(met_pkg::CFG_MAX_ITER, 32'd1);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_for_drain();
  endtask

  task automatic test_saturated_points;
    // step writes carry bit 31 set, which the 31-bit registers drop
    write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1);
    wait_for_drain();
    write_register(met_pkg::CFG_X_LEFT, 32'h8000_0000);
    write_register(met_pkg::CFG_Y_TOP, 32'h7FFF_FFFF);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd1023, 10'd0);
    wait_for_drain();
  endtask

  task automatic test_deepest_limit;
    // zero origin and steps put every pixel at c = 0, which never escapes
    write_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
    send_random_pixels(3);
    wait_for_drain();
  endtask

  task automatic test_output_backpressure;
    write_view(32'hE000_0000, 32'h1000_0000, 32'd786432, 32'd524288, 32'd24);
    hold_request = 1'b1;
    send_random_pixels(30);
    wait_for_drain();
  endtask

  task automatic test_random_views;
    logic [31:0] limit;
    for (int v = 0; v < VIEWS; v++) begin
      limit = $urandom_range(2, 400);
      if (v == 0) begin
        write_view(32'hE000_0000, 32'h1000_0000, 32'd786432, 32'd524288, 32'd255);
      end else if (v == VIEWS - 1) begin
        // raw register contents, upper bits of the limit write are junk
        write_view($urandom, $urandom, $urandom, $urandom,
                   {16'($urandom), limit[15:0]});
      end else begin
        write_view(32'(-536870912 + int'($urandom_range(0, 536870912))),
                   32'($urandom_range(0, 268435456)),
                   32'($urandom_range(1, 1 << 20)), 32'($urandom_range(1, 1 << 20)),
                   limit);
      end
      if (v == 0) begin
        steady = 1'b1;
        send_random_pixels(STEADY_PIXELS);
        steady = 1'b0;
        send_random_pixels(PIXELS_PER_VIEW - STEADY_PIXELS);
      end else begin
        send_random_pixels(PIXELS_PER_VIEW);
      end
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_iteration_limits();
    test_saturated_points();
    test_deepest_limit();
    test_output_backpressure();
    test_random_views();
    repeat (4 * (int'(iter_limit) + 1) + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
